/* rtl/core/byte_block_entropy_core_defines.svh */
// assertion macros for the byte block entropy core
`ifndef BYTE_BLOCK_ENTROPY_CORE_DEFINES_SVH
`define BYTE_BLOCK_ENTROPY_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BBE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBE_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBE_ASSERT(label, clk, rst_n, prop, msg)
`define BBE_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* rtl/core/bbe_pkg.sv */
package bbe_pkg;
    localparam int MaxBytes = 1048576;
    localparam int FracBits = 16;
    localparam int NumBins  = 256;
    localparam int CntW     = 21;
    localparam int BinW     = 8;
    localparam int LogW     = 5 + FracBits;   // integer part up to 20
    localparam int SumW     = 42;
    localparam int EntW     = 20;
    localparam int YW       = FracBits + 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [EntW-1:0] entropy;
        logic            too_long;
    } t_out;

    // controller -> datapath commands
    typedef struct packed {
        logic count_en;     // accepted beat, read its bin
        logic inc_en;       // write back incremented bin
        logic clr_en;       // clear histogram entry at scan index
        logic scan_rd;      // read bin at scan index
        logic log_start;    // start log unit on loaded operand
        logic log_sel_n;    // 1: log of n, 0: log of bin
        logic acc_en;       // accumulate c * log c
        logic div_start;
        logic finish;       // form result
        logic reset_blk;    // clear count, sum, flag
    } t_cmd;

    typedef struct packed {
        logic log_done;
        logic div_done;
        logic bin_zero;
    } t_sts;
endpackage

/* rtl/core/bbe_ctrl.sv */
`include "byte_block_entropy_core_defines.svh"
module bbe_ctrl
    import bbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_last,
    output logic       o_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic [7:0] o_scan_idx
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_LOG   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_NLOG0 = 4'd5;
    localparam logic [3:0] S_NLOG  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_INC   = 4'd10;

    logic [3:0] r_state, n_state;
    logic [8:0] r_idx, n_idx;
    logic       r_ovalid, n_ovalid;
    logic       r_last, n_last;

    assign o_scan_idx  = r_idx[7:0];
    assign o_out_valid = r_ovalid;
    assign o_ready     = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.count_en = 1'b1;
                    n_last  = i_last;
                    n_state = S_INC;
                end
            end
            S_INC: begin
                o_cmd.inc_en = 1'b1;
                if (r_last) begin
                    n_state = S_RD;
                    n_idx   = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.bin_zero) begin
                    n_idx = r_idx + 9'd1;
                    n_state = (r_idx == 9'd255) ? S_NLOG0 : S_RD;
                end else begin
                    o_cmd.log_start = 1'b1;
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                if (i_sts.log_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_idx = r_idx + 9'd1;
                n_state = (r_idx == 9'd255) ? S_NLOG0 : S_RD;
            end
            S_NLOG0: begin
                o_cmd.log_start = 1'b1;
                o_cmd.log_sel_n = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_NLOG;
            end
            S_NLOG: begin
                if (i_sts.log_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    o_cmd.reset_blk = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                    n_idx    = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            r_last   <= n_last;
        end
    end

    `BBE_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> !o_ready, "accept while busy")
    `BBE_ASSERT(a_out_hold, i_clk, i_rst_n, (r_ovalid && !i_out_ready) |=> r_ovalid, "result dropped")
    `BBE_ASSERT(a_fin_out, i_clk, i_rst_n, o_cmd.finish |=> (r_state == S_OUT), "finish order")
endmodule

/* rtl/core/bbe_log2.sv */
module bbe_log2
    import bbe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [CntW-1:0] i_x,
    output logic            o_done,
    output logic [LogW-1:0] o_log
);
    localparam int KW = $clog2(FracBits + 1);
    logic [YW-1:0]       r_y;
    logic [FracBits-1:0] r_frac;
    logic [4:0]          r_top;
    logic [KW-1:0]       r_k;
    logic                r_busy;
    logic [4:0]          w_top;
    logic [2*YW-1:0]     w_sq;
    logic [YW-1:0]       w_ys;

    always_comb begin
        w_top = '0;
        for (int i = 0; i < CntW; i++) begin
            if (i_x[i]) w_top = 5'(i);
        end
    end

    assign w_sq  = (2*YW)'(r_y) * (2*YW)'(r_y);
    assign w_ys  = YW'(w_sq >> FracBits);
    assign o_log = {r_top, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_top  <= w_top;
                r_frac <= '0;
                if (int'(w_top) <= FracBits)
                    r_y <= YW'({{(YW){1'b0}}, i_x} << (FracBits - int'(w_top)));
                else
                    r_y <= YW'(i_x >> (int'(w_top) - FracBits));
            end else if (r_busy) begin
                if (w_ys[YW-1]) begin
                    r_y    <= w_ys >> 1;
                    r_frac <= {r_frac[FracBits-2:0], 1'b1};
                end else begin
                    r_y    <= w_ys;
                    r_frac <= {r_frac[FracBits-2:0], 1'b0};
                end
                r_k <= r_k + KW'(1);
                if (r_k == KW'(FracBits - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* rtl/core/bbe_div.sv */
module bbe_div
    import bbe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SumW-1:0] i_num,
    input  logic [CntW-1:0] i_den,
    output logic            o_done,
    output logic [SumW-1:0] o_quot
);
    localparam int IW = $clog2(SumW + 1);
    logic [SumW-1:0] r_num;
    logic [CntW:0]   r_rem;
    logic [CntW-1:0] r_den;
    logic [IW-1:0]   r_i;
    logic            r_busy;
    logic [CntW:0]   w_sh;

    assign w_sh = {r_rem[CntW-1:0], r_num[SumW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_i    <= '0;
                o_quot <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem  <= w_sh - {1'b0, r_den};
                    o_quot <= {o_quot[SumW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    o_quot <= {o_quot[SumW-2:0], 1'b0};
                end
                r_i <= r_i + IW'(1);
                if (r_i == IW'(SumW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* rtl/core/bbe_dp.sv */
`include "byte_block_entropy_core_defines.svh"
module bbe_dp
    import bbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in        i_in,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_scan_idx,
    output t_sts       o_sts,
    output t_out       o_out
);
    logic [CntW-1:0] r_mem [NumBins];
    logic [NumBins-1:0] r_vld;
    logic [CntW-1:0] r_c;
    logic            r_cvld;
    logic [CntW-1:0] r_n;
    logic            r_ovf;
    logic [SumW-1:0] r_sum;
    logic [SumW-1:0] r_prod;
    logic            r_prod_v;
    logic [7:0]      r_b;
    logic            r_wen;
    logic [7:0]      w_rd_addr;
    logic [CntW-1:0] w_bin;
    logic [CntW-1:0] w_lx;
    logic [LogW-1:0] w_log;
    logic            w_log_done;
    logic [SumW-1:0] w_quot;
    logic            w_div_done;
    logic [LogW-1:0] r_ln;
    logic [LogW:0]   w_h;

    // one registered read port: the accepted byte's bin, else the scan bin
    assign w_rd_addr = i_cmd.count_en ? i_in.data_byte : i_scan_idx;

    // histogram: read on the accept cycle, incremented write back the next
    always_ff @(posedge i_clk) begin
        if (i_cmd.inc_en && r_wen)
            r_mem[r_b] <= (r_vld[r_b] ? r_c : '0) + CntW'(1);
        r_c <= r_mem[w_rd_addr];
        if (i_cmd.count_en) begin
            r_b   <= i_in.data_byte;
            r_wen <= (r_n < CntW'(MaxBytes));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_cvld <= 1'b0;
        end else begin
            if (i_cmd.scan_rd) r_cvld <= r_vld[i_scan_idx];
            if (i_cmd.inc_en && r_wen)
                r_vld[r_b] <= 1'b1;
            if (i_cmd.clr_en) r_vld[i_scan_idx] <= 1'b0;
        end
    end

    assign w_bin = r_cvld ? r_c : '0;
    assign o_sts.bin_zero = (w_bin == '0);
    assign w_lx = i_cmd.log_sel_n ? r_n : w_bin;

    bbe_log2 u_log (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.log_start),
        .i_x    (w_lx),
        .o_done (w_log_done),
        .o_log  (w_log)
    );

    bbe_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_sum),
        .i_den  (r_n),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign o_sts.log_done = w_log_done;
    assign o_sts.div_done = w_div_done;

    always_ff @(posedge i_clk) begin
        if (w_log_done) begin
            r_prod <= SumW'(w_bin) * SumW'(w_log);
            r_ln   <= w_log;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_ovf    <= 1'b0;
            r_sum    <= '0;
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= w_log_done;
            if (i_cmd.count_en) begin
                if (r_n >= CntW'(MaxBytes)) r_ovf <= 1'b1;
                else r_n <= r_n + CntW'(1);
            end
            if (i_cmd.acc_en) r_sum <= r_sum + r_prod;
            if (i_cmd.reset_blk) begin
                r_n   <= '0;
                r_ovf <= 1'b0;
                r_sum <= '0;
            end
        end
    end

    assign w_h = ((r_n != '0) && (SumW'(r_ln) > w_quot))
               ? (LogW+1)'(SumW'(r_ln) - w_quot) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out.entropy  <= (w_h > (LogW+1)'(8 << FracBits)) ? EntW'(8 << FracBits)
                                                               : EntW'(w_h);
            o_out.too_long <= r_ovf;
        end
    end

    `BBE_ASSERT(a_acc_after_prod, i_clk, i_rst_n, i_cmd.acc_en |-> r_prod_v, "acc before product")
    `BBE_ASSERT(a_n_cap, i_clk, i_rst_n, r_n <= CntW'(MaxBytes), "byte count beyond limit")
    `BBE_ASSERT(a_ovf_full, i_clk, i_rst_n, r_ovf |-> (r_n == CntW'(MaxBytes)), "overflow without full count")
endmodule

/* rtl/core/byte_block_entropy_core.sv */
// byte block entropy core
// input channel: one byte per beat (i_in_valid / o_in_ready), the beat with
// last set closes the block. output channel: one result beat per block
// (o_out_valid / i_out_ready) carrying entropy in bits per byte, unsigned
// q4.16, and the too_long flag.
// a byte's histogram bin is read on the accept cycle and written back the
// next; no new byte is taken until that write-back is done.
// after the last byte a scan walks all 256 histogram bins: an empty bin
// is read and checked, a filled bin also goes through the 16-step
// square-and-shift log unit and is accumulated; then the log of the byte
// count and a 42-step restoring divider run together.
// each bin is cleared as it is scanned and the result sits in its own
// register, so the next block streams in while the receiver stalls; that
// block's result waits before its final step until the old beat is taken.
// reset clears all histogram valid bits, the count and the flag at once.
module byte_block_entropy_core
    import bbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [7:0] w_idx;

    // sequencer for count, scan, log, divide and result
    bbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_last     (i_in.last),
        .o_ready    (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_scan_idx (w_idx)
    );

    // histogram, log unit, divider and result register
    bbe_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cmd     (w_cmd),
        .i_scan_idx(w_idx),
        .o_sts     (w_sts),
        .o_out     (o_out)
    );
endmodule

/* tb/sv/tb_byte_block_entropy_core.sv */
module tb_byte_block_entropy_core;
    import bbe_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    byte_block_entropy_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // watchdog limit in cycles with no accepted beat; it must cover the
    // longest scan plus receiver stalls
    localparam int unsigned IdleLimit = 40000;
    localparam int unsigned DrainCycles = 6000;

    // predictor state
    logic [CntW-1:0] bin_count [NumBins];
    logic [CntW-1:0] bytes_seen;
    logic            overrun;

    // expected results, oldest first
    t_out entropy_q[$];
    // directed rows: byte, last, typed-in expectation valid, expected beat
    typedef struct {
        logic [7:0] b;
        logic       l;
        logic       has_exp;
        t_out       exp;
    } t_row;
    t_row rows[$];

    logic        failed;
    logic        done_feeding;
    int unsigned idle_cycles;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // truncated log2 with FracBits fraction bits, square-and-shift
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        logic [63:0] top;
        logic [63:0] y;
        logic [63:0] frac;
        top = 0;
        frac = 0;
        if (x == 0) begin
            return 0;
        end
        while (top < 63 && (x >> (top + 1)) != 0) begin
            top++;
        end
        if (top <= FracBits) begin
            y = x << (FracBits - top);
        end else begin
            y = x >> (top - FracBits);
        end
        for (int k = 0; k < FracBits; k++) begin
            y = (y * y) >> FracBits;
            frac = frac << 1;
            if (y >= (64'd2 << FracBits)) begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return (top << FracBits) | frac;
    endfunction

    function automatic void clear_histogram();
        for (int i = 0; i < NumBins; i++) begin
            bin_count[i] = '0;
        end
        bytes_seen = '0;
        overrun = 1'b0;
    endfunction

    // count one byte; on the last byte push the expected entropy beat
    function automatic void count_byte(input t_in beat, input logic has_exp,
                                       input t_out typed);
        logic [63:0] sum;
        logic [63:0] h;
        logic [63:0] n;
        logic [63:0] ln;
        logic [63:0] quot;
        t_out        r;
        if (bytes_seen >= MaxBytes) begin
            overrun = 1'b1;
        end else begin
            bin_count[beat.data_byte]++;
            bytes_seen++;
        end
        if (!beat.last) begin
            return;
        end
        sum = 0;
        for (int i = 0; i < NumBins; i++) begin
            if (bin_count[i] != 0) begin
                sum += 64'(bin_count[i]) * log2_fixed(64'(bin_count[i]));
            end
        end
        n = 64'(bytes_seen);
        if (n == 0) begin
            h = 0;
        end else begin
            ln = log2_fixed(n);
            quot = sum / n;
            h = (ln > quot) ? ln - quot : 0;
        end
        if (h > (64'd8 << FracBits)) begin
            h = 64'd8 << FracBits;
        end
        r.entropy = h[EntW-1:0];
        r.too_long = overrun;
        // a typed-in row must agree with the predictor too
        if (has_exp && typed != r) begin
            $display("%0t predictor disagrees with table: exp %h got %h",
                     $time, typed, r);
            failed = 1'b1;
        end
        entropy_q.push_back(has_exp ? typed : r);
        clear_histogram();
    endfunction

    // feed one byte beat with a random gap before it
    task automatic send_byte(input logic [7:0] b, input logic l, input logic has_exp,
                             input t_out typed);
        t_in beat;
        int  gap;
        gap = $urandom_range(0, 7);
        // gaps only on some stretches so back-to-back streaming happens too
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat.data_byte = b;
        beat.last = l;
        i_in <= beat;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        count_byte(beat, has_exp, typed);
    endtask

    task automatic add_row(input logic [7:0] b, input logic l, input logic has_exp,
                           input logic [EntW-1:0] e);
        t_row r;
        r.b = b;
        r.l = l;
        r.has_exp = has_exp;
        r.exp.entropy = e;
        r.exp.too_long = 1'b0;
        rows.push_back(r);
    endtask

    // stimulus
    initial begin
        t_out none;
        int   len;
        int   kind;
        int   nblocks;
        none = '0;
        failed = 1'b0;
        done_feeding = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        clear_histogram();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single byte blocks: entropy 0 at both extremes of the byte
        add_row(8'h00, 1'b1, 1'b1, '0);
        add_row(8'hFF, 1'b1, 1'b1, '0);
        // two equal bytes: entropy 0
        add_row(8'hA5, 1'b0, 1'b0, '0);
        add_row(8'hA5, 1'b1, 1'b1, '0);
        // two distinct bytes: exactly one bit per byte
        add_row(8'h55, 1'b0, 1'b0, '0);
        add_row(8'hAA, 1'b1, 1'b1, 20'h10000);
        // four distinct bytes: two bits per byte
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, '0);
        add_row(8'h04, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b1, 1'b1, 20'h20000);
        // skewed block, predictor only
        add_row(8'h7F, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b0, 1'b0, '0);
        add_row(8'h10, 1'b0, 1'b0, '0);
        add_row(8'h20, 1'b1, 1'b0, '0);
        foreach (rows[i]) begin
            send_byte(rows[i].b, rows[i].l, rows[i].has_exp,
                      rows[i].has_exp ? rows[i].exp : none);
        end
        // full 256-value block: eight bits per byte, the saturation edge
        for (int v = 0; v < NumBins; v++) begin
            send_byte(8'(v), v == NumBins - 1, v == NumBins - 1, '{20'h80000, 1'b0});
        end

        // random blocks, mostly short ones with varied alphabets
        nblocks = 0;
        while (nblocks < 45) begin
            kind = $urandom_range(0, 3);
            len = (kind == 0) ? $urandom_range(1, 3) : $urandom_range(2, 16);
            for (int k = 0; k < len; k++) begin
                logic [7:0] b;
                case (kind)
                    1: b = 8'($urandom_range(0, 1)) ^ 8'hF0;
                    2: b = 8'($urandom_range(0, 7));
                    default: b = 8'($urandom);
                endcase
                send_byte(b, k == len - 1, 1'b0, none);
            end
            nblocks++;
        end
        i_in_valid <= 1'b0;
        // block length beyond MaxBytes is far too long to simulate here;
        // the too_long path is left to a build with a small MaxBytes
        done_feeding = 1'b1;
    end

    // receiver with random stalls
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) begin
                @(posedge i_clk);
            end
        end
    end

    // result check on every accepted output beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (entropy_q.size() == 0) begin
                $display("%0t unexpected result beat: exp none got %h", $time, o_out);
                failed = 1'b1;
            end else begin
                t_out e;
                e = entropy_q.pop_front();
                if (e.entropy !== o_out.entropy) begin
                    $display("%0t entropy: exp %h got %h", $time, e.entropy,
                             o_out.entropy);
                    failed = 1'b1;
                end
                if (e.too_long !== o_out.too_long) begin
                    $display("%0t too_long: exp %b got %b", $time, e.too_long,
                             o_out.too_long);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
    initial begin
        idle_cycles = 0;
        wait (idle_cycles >= IdleLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // end of run
    initial begin
        wait (done_feeding);
        wait (entropy_q.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (!failed && entropy_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
